// File: design/assert_macros.svh
// Assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset
`define AST_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen outside reset
`define AST_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: design/smx_pkg.sv
package smx_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 15;
    localparam int MASK_W     = 4;
    localparam int RADIX      = 14;

    // Source lanes
    localparam int MAX_SOURCES      = 4;
    localparam int SOURCE_COUNT_DEF = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Arithmetic widths: product of signed sample and unsigned gain, plus headroom
    // for the shifted existing sample and every source
    localparam int PROD_W = SAMPLE_W + GAIN_W;
    localparam int ACC_W  = PROD_W + 3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [GAIN_W-1:0]   t_gain;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;

    localparam t_gain GAIN_UNITY = t_gain'(1 << RADIX);
    localparam t_acc  ROUND_BIAS = t_acc'(1) <<< (RADIX - 1);
    localparam t_acc  SAT_MAX    = t_acc'((1 << (SAMPLE_W - 1)) - 1);
    localparam t_acc  SAT_MIN    = t_acc'(-(1 << (SAMPLE_W - 1)));

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE_MASK = 3'd0,
        REG_GAIN_ZERO   = 3'd1,
        REG_GAIN_ONE    = 3'd2,
        REG_GAIN_TWO    = 3'd3,
        REG_GAIN_THREE  = 3'd4
    } t_cfg_reg;

    // Request travelling alongside the lane products
    typedef struct packed {
        logic    block_end;
        t_sample existing;
    } t_mix_req;

    // Finished result
    typedef struct packed {
        logic    block_end;
        t_sample mixed;
    } t_mix_res;

endpackage

// File: design/smx_lane.sv
module smx_lane (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_enable,
    input  smx_pkg::t_sample i_sample,
    input  smx_pkg::t_gain   i_gain,
    output smx_pkg::t_prod   o_product
);

    smx_pkg::t_prod r_product;
    smx_pkg::t_prod n_product;

    // Gain multiply; a disabled source contributes nothing
    always_comb begin
        if (i_enable) begin
            n_product = smx_pkg::t_prod'(i_sample)
                      * smx_pkg::t_prod'($signed({1'b0, i_gain}));
        end else begin
            n_product = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_product <= n_product;
        end
    end

    assign o_product = r_product;

endmodule

// File: design/smx_mix.sv
module smx_mix #(
    parameter int SOURCE_COUNT = smx_pkg::SOURCE_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_load,
    input  smx_pkg::t_mix_req i_req,
    input  smx_pkg::t_prod    i_product [SOURCE_COUNT],
    output smx_pkg::t_mix_res o_res
);

    smx_pkg::t_acc     w_sum;
    smx_pkg::t_acc     w_shifted;
    smx_pkg::t_mix_res r_res;
    smx_pkg::t_mix_res n_res;

    // Accumulate existing sample (scaled up) and the lane products, then round
    always_comb begin
        w_sum = smx_pkg::t_acc'(i_req.existing) <<< smx_pkg::RADIX;
        for (int k = 0; k < SOURCE_COUNT; k++) begin
            w_sum = w_sum + smx_pkg::t_acc'(i_product[k]);
        end
        w_sum     = w_sum + smx_pkg::ROUND_BIAS;
        w_shifted = w_sum >>> smx_pkg::RADIX;
    end

    // Saturate to the sample range
    always_comb begin
        n_res.block_end = i_req.block_end;
        if (w_shifted > smx_pkg::SAT_MAX) begin
            n_res.mixed = smx_pkg::SAT_MAX[smx_pkg::SAMPLE_W-1:0];
        end else if (w_shifted < smx_pkg::SAT_MIN) begin
            n_res.mixed = smx_pkg::SAT_MIN[smx_pkg::SAMPLE_W-1:0];
        end else begin
            n_res.mixed = w_shifted[smx_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// File: design/saturating_gain_audio_mixer.sv
// Q14 gain mixer: each request carries one sample frame (existing output sample plus one
// sample per source) and yields one rounded, saturated sample. One request is taken every
// clock cycle while o_stall is low; o_valid rises once that request has passed the input register,
// the registered gain multiply per source lane and the registered sum/round/saturate.
// Bubbles close up: while a finished result is held by i_stall the two stages behind it
// still fill, so up to two more requests are taken before o_stall rises. The user must
// write gains and the enable mask through the configuration port only while no request is
// in flight; the block itself does not enforce this. Sources at or above SOURCE_COUNT are
// ignored.
module saturating_gain_audio_mixer #(
    parameter int SOURCE_COUNT = smx_pkg::SOURCE_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration
    input  logic                            i_cfg_wr_en,
    input  logic [smx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [smx_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [smx_pkg::SAMPLE_W-1:0] i_existing_sample,
    input  logic signed [smx_pkg::SAMPLE_W-1:0] i_source_sample_zero,
    input  logic signed [smx_pkg::SAMPLE_W-1:0] i_source_sample_one,
    input  logic signed [smx_pkg::SAMPLE_W-1:0] i_source_sample_two,
    input  logic signed [smx_pkg::SAMPLE_W-1:0] i_source_sample_three,
    input  logic                            i_block_end,
    // Output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [smx_pkg::SAMPLE_W-1:0] o_mixed_sample,
    output logic                            o_block_end_out
);

    // Configuration registers
    logic [smx_pkg::MASK_W-1:0] r_enable_mask;
    smx_pkg::t_gain             r_gain [smx_pkg::MAX_SOURCES];

    // Pipeline state
    logic              r_a_valid;
    smx_pkg::t_mix_req r_a_req;
    smx_pkg::t_sample  r_a_src [smx_pkg::MAX_SOURCES];
    logic              r_b_valid;
    smx_pkg::t_mix_req r_b_req;
    logic              r_c_valid;

    smx_pkg::t_sample  w_src [smx_pkg::MAX_SOURCES];
    smx_pkg::t_prod    w_product [SOURCE_COUNT];
    smx_pkg::t_mix_res w_res;
    logic              w_adv_a;
    logic              w_adv_b;
    logic              w_adv_c;

    assign w_src[0] = i_source_sample_zero;
    assign w_src[1] = i_source_sample_one;
    assign w_src[2] = i_source_sample_two;
    assign w_src[3] = i_source_sample_three;

    // A stage moves on when it is empty or the next one moves on
    assign w_adv_c = !r_c_valid || !i_stall;
    assign w_adv_b = !r_b_valid || w_adv_c;
    assign w_adv_a = !r_a_valid || w_adv_b;
    assign o_stall = !w_adv_a;

    // Configuration writes; indexes past the last gain are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask <= '0;
            for (int k = 0; k < smx_pkg::MAX_SOURCES; k++) begin
                r_gain[k] <= smx_pkg::GAIN_UNITY;
            end
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                smx_pkg::REG_ENABLE_MASK: r_enable_mask <= i_cfg_data[smx_pkg::MASK_W-1:0];
                smx_pkg::REG_GAIN_ZERO:   r_gain[0]     <= i_cfg_data[smx_pkg::GAIN_W-1:0];
                smx_pkg::REG_GAIN_ONE:    r_gain[1]     <= i_cfg_data[smx_pkg::GAIN_W-1:0];
                smx_pkg::REG_GAIN_TWO:    r_gain[2]     <= i_cfg_data[smx_pkg::GAIN_W-1:0];
                smx_pkg::REG_GAIN_THREE:  r_gain[3]     <= i_cfg_data[smx_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Valid bits of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_adv_a) begin
                r_a_valid <= i_valid;
            end
            if (w_adv_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_adv_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_adv_a) begin
            r_a_req.existing  <= i_existing_sample;
            r_a_req.block_end <= i_block_end;
            for (int k = 0; k < smx_pkg::MAX_SOURCES; k++) begin
                r_a_src[k] <= w_src[k];
            end
        end
        if (w_adv_b) begin
            r_b_req <= r_a_req;
        end
    end

    // One gain multiplier per source lane below SOURCE_COUNT, enabled or not
    for (genvar g = 0; g < SOURCE_COUNT; g++) begin : g_lane
        smx_lane u_lane (
            .i_clk     (i_clk),
            .i_load    (w_adv_b),
            .i_enable  (r_enable_mask[g]),
            .i_sample  (r_a_src[g]),
            .i_gain    (r_gain[g]),
            .o_product (w_product[g])
        );
    end

    // Sum, round and saturate into the result register
    smx_mix #(
        .SOURCE_COUNT (SOURCE_COUNT)
    ) u_mix (
        .i_clk     (i_clk),
        .i_load    (w_adv_c),
        .i_req     (r_b_req),
        .i_product (w_product),
        .o_res     (w_res)
    );

    assign o_valid         = r_c_valid;
    assign o_mixed_sample  = w_res.mixed;
    assign o_block_end_out = w_res.block_end;

    // Checks
    `include "assert_macros.svh"

    `AST_HOLDS(a_stall_full, i_clk, i_rst_n, o_stall |-> (r_a_valid && r_b_valid && r_c_valid && i_stall), "input stalled with room in the pipeline")
    `AST_HOLDS(a_result_kept, i_clk, i_rst_n, (r_c_valid && i_stall) |=> r_c_valid, "stalled result dropped")
    `AST_HOLDS(a_mid_moves, i_clk, i_rst_n, (r_b_valid && w_adv_c) |=> r_c_valid, "product stage lost a request")
    `AST_HOLDS(a_out_steady, i_clk, i_rst_n, (o_valid && i_stall) |=> ($stable(o_mixed_sample) && $stable(o_block_end_out)), "stalled result changed")

endmodule

// File: test/saturating_gain_audio_mixer_tb.sv
module saturating_gain_audio_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    localparam int LANES        = smx_pkg::SOURCE_COUNT_DEF;
    localparam int PIPE_DEPTH   = 3;
    localparam int IDLE_PCT     = 27;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 138;
    localparam int STALL_LIMIT  = 2000;

    // Register indexes the block does not decode
    localparam logic [smx_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
    localparam logic [smx_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam logic [smx_pkg::GAIN_W-1:0] GAIN_MAX  = 15'h7FFF;
    localparam logic [smx_pkg::GAIN_W-1:0] GAIN_NONE = 15'h0000;

    // One sample frame as presented on the input channel
    typedef struct packed {
        logic                                       block_end;
        smx_pkg::t_sample                           existing;
        smx_pkg::t_sample [smx_pkg::MAX_SOURCES-1:0] src;
    } t_frame;

    // Directed script: either a register write or a request
    typedef struct {
        bit                               is_cfg;
        logic [smx_pkg::CFG_IDX_W-1:0]    idx;
        logic [smx_pkg::CFG_DATA_W-1:0]   data;
        t_frame                           frame;
        bit                               fixed;
        smx_pkg::t_sample                 want;
    } t_step;

    logic clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [smx_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [smx_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic i_valid;
    logic o_stall;
    logic signed [smx_pkg::SAMPLE_W-1:0] i_existing_sample;
    logic signed [smx_pkg::SAMPLE_W-1:0] i_source_sample_zero;
    logic signed [smx_pkg::SAMPLE_W-1:0] i_source_sample_one;
    logic signed [smx_pkg::SAMPLE_W-1:0] i_source_sample_two;
    logic signed [smx_pkg::SAMPLE_W-1:0] i_source_sample_three;
    logic i_block_end;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [smx_pkg::SAMPLE_W-1:0] o_mixed_sample;
    logic o_block_end_out;

    // Predictor copy of the registers
    logic [smx_pkg::MASK_W-1:0] mix_mask;
    logic [smx_pkg::GAIN_W-1:0] mix_gain [smx_pkg::MAX_SOURCES];

    smx_pkg::t_mix_res pending_mix [$];
    t_step    script [$];
    bit       calm = 1'b0;
    int       errors = 0;
    int       frames_sent = 0;
    int       results_seen = 0;
    int       reg_writes = 0;
    int       idle_cycles = 0;

    saturating_gain_audio_mixer #(
        .SOURCE_COUNT (LANES)
    ) dut (
        .i_clk                 (clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_existing_sample     (i_existing_sample),
        .i_source_sample_zero  (i_source_sample_zero),
        .i_source_sample_one   (i_source_sample_one),
        .i_source_sample_two   (i_source_sample_two),
        .i_source_sample_three (i_source_sample_three),
        .i_block_end           (i_block_end),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_mixed_sample        (o_mixed_sample),
        .o_block_end_out       (o_block_end_out)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Register file as the block should see it
    function automatic void apply_register(logic [smx_pkg::CFG_IDX_W-1:0] idx,
                                           logic [smx_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            smx_pkg::REG_ENABLE_MASK: begin
                mix_mask = data[smx_pkg::MASK_W-1:0];
            end
            smx_pkg::REG_GAIN_ZERO, smx_pkg::REG_GAIN_ONE, smx_pkg::REG_GAIN_TWO,
            smx_pkg::REG_GAIN_THREE: begin
                mix_gain[idx - smx_pkg::REG_GAIN_ZERO] = data[smx_pkg::GAIN_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Q14 mix: shifted existing sample plus gained sources, round, floor shift, clamp
    function automatic smx_pkg::t_mix_res mix_predict(t_frame f);
        longint            acc;
        longint            s;
        longint            g;
        smx_pkg::t_mix_res r;
        acc = $signed(f.existing);
        acc = acc * (longint'(1) << smx_pkg::RADIX);
        for (int k = 0; k < LANES; k++) begin
            if (mix_mask[k]) begin
                s = $signed(f.src[k]);
                g = mix_gain[k];
                acc += s * g;
            end
        end
        acc += longint'(1) << (smx_pkg::RADIX - 1);
        acc = acc >>> smx_pkg::RADIX;
        if (acc > 32767)
            acc = 32767;
        else if (acc < -32768)
            acc = -32768;
        r.mixed     = smx_pkg::t_sample'(acc);
        r.block_end = f.block_end;
        return r;
    endfunction

    function automatic t_step item_row(int ex, int s0, int s1, int s2, int s3, bit be,
                                       bit fixed = 1'b0, int want = 0);
        t_step r;
        r.is_cfg            = 1'b0;
        r.idx               = '0;
        r.data              = '0;
        r.frame.existing    = smx_pkg::t_sample'(ex);
        r.frame.src[0]      = smx_pkg::t_sample'(s0);
        r.frame.src[1]      = smx_pkg::t_sample'(s1);
        r.frame.src[2]      = smx_pkg::t_sample'(s2);
        r.frame.src[3]      = smx_pkg::t_sample'(s3);
        r.frame.block_end   = be;
        r.fixed             = fixed;
        r.want              = smx_pkg::t_sample'(want);
        return r;
    endfunction

    function automatic t_step cfg_row(logic [smx_pkg::CFG_IDX_W-1:0] idx, int data);
        t_step r;
        r        = item_row(0, 0, 0, 0, 0, 1'b0);
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = smx_pkg::CFG_DATA_W'(data);
        return r;
    endfunction

    // Extremes, small values or zero, but mostly anywhere in range
    function automatic smx_pkg::t_sample pick_sample();
        case ($urandom_range(9))
            0: return smx_pkg::t_sample'(32767);
            1: return smx_pkg::t_sample'(-32768);
            2: return smx_pkg::t_sample'($signed($urandom_range(0, 127)) - 64);
            3: return '0;
            default: return smx_pkg::t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [smx_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(5))
            0: return GAIN_NONE;
            1: return GAIN_MAX;
            2: return smx_pkg::GAIN_UNITY;
            default: return smx_pkg::GAIN_W'($urandom);
        endcase
    endfunction

    function automatic t_frame random_frame();
        t_frame f;
        f.existing  = pick_sample();
        for (int k = 0; k < smx_pkg::MAX_SOURCES; k++)
            f.src[k] = pick_sample();
        f.block_end = ($urandom_range(3) == 0);
        return f;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s on result %0d: got %0d, want %0d",
                 what, results_seen, got, want);
        errors++;
    endtask

    // Offer one request, holding it until taken, and log what it should produce
    task automatic push_frame(t_frame f, bit fixed, smx_pkg::t_sample want);
        smx_pkg::t_mix_res r;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_valid               <= 1'b1;
        i_existing_sample     <= f.existing;
        i_source_sample_zero  <= f.src[0];
        i_source_sample_one   <= f.src[1];
        i_source_sample_two   <= f.src[2];
        i_source_sample_three <= f.src[3];
        i_block_end           <= f.block_end;
        do @(posedge clk); while (o_stall);
        if (fixed) begin
            r.mixed     = want;
            r.block_end = f.block_end;
        end else begin
            r = mix_predict(f);
        end
        pending_mix.push_back(r);
        frames_sent++;
    endtask

    // Stop sending and let the pipeline empty out
    task automatic drain_mixer();
        i_valid <= 1'b0;
        while (pending_mix.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_register(logic [smx_pkg::CFG_IDX_W-1:0] idx,
                                  logic [smx_pkg::CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge clk);
        apply_register(idx, data);
        i_cfg_wr_en <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // Settings for each random phase: full gain, zero gain, unity, muted, then random
    task automatic setup_phase(int ph);
        logic [smx_pkg::CFG_DATA_W-1:0] m;
        logic [smx_pkg::GAIN_W-1:0]     g [smx_pkg::MAX_SOURCES];
        for (int k = 0; k < smx_pkg::MAX_SOURCES; k++)
            g[k] = pick_gain();
        case (ph)
            0: begin
                m = 15'h000F;
                foreach (g[k]) g[k] = GAIN_MAX;
            end
            1: begin
                m = 15'h7FFF;
                foreach (g[k]) g[k] = GAIN_NONE;
            end
            2: begin
                m = 15'h000F;
                foreach (g[k]) g[k] = smx_pkg::GAIN_UNITY;
            end
            3: m = '0;
            default: m = smx_pkg::CFG_DATA_W'($urandom);
        endcase
        drain_mixer();
        write_register(smx_pkg::REG_ENABLE_MASK, m);
        for (int k = 0; k < smx_pkg::MAX_SOURCES; k++)
            write_register(smx_pkg::CFG_IDX_W'(smx_pkg::REG_GAIN_ZERO + k), g[k]);
        if (ph >= 4)
            write_register(smx_pkg::CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)),
                           smx_pkg::CFG_DATA_W'($urandom));
    endtask

    // Receiver back-pressure
    always @(posedge clk)
        i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

    // Result checker
    always @(posedge clk) begin : result_check
        smx_pkg::t_mix_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_mix.size() == 0) begin
                report_mismatch("result with nothing outstanding", o_mixed_sample, 0);
            end else begin
                want = pending_mix.pop_front();
                if (o_mixed_sample !== want.mixed)
                    report_mismatch("mixed_sample", o_mixed_sample, want.mixed);
                if (o_block_end_out !== want.block_end)
                    report_mismatch("block_end_out", o_block_end_out, want.block_end);
            end
            results_seen++;
        end
    end

    // Watchdog on cycles without any handshake on either side
    always @(posedge clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_wr_en           <= 1'b0;
        i_cfg_index           <= '0;
        i_cfg_data            <= '0;
        i_valid               <= 1'b0;
        i_existing_sample     <= '0;
        i_source_sample_zero  <= '0;
        i_source_sample_one   <= '0;
        i_source_sample_two   <= '0;
        i_source_sample_three <= '0;
        i_block_end           <= 1'b0;
        mix_mask = '0;
        foreach (mix_gain[k]) mix_gain[k] = smx_pkg::GAIN_UNITY;

        // Directed script; typed expectations where the answer is obvious
        // Reset state: nothing enabled, output follows the existing sample
        script.push_back(item_row(0, 32767, 32767, 32767, 32767, 1'b0, 1'b1, 0));
        script.push_back(item_row(32767, -32768, -32768, -32768, -32768, 1'b1, 1'b1, 32767));
        script.push_back(item_row(-32768, 32767, 32767, 32767, 32767, 1'b0, 1'b1, -32768));
        // Wide write to the mask keeps the low four bits only
        script.push_back(cfg_row(smx_pkg::REG_ENABLE_MASK, 'h7FFF));
        script.push_back(item_row(0, 1000, 2000, 3000, 4000, 1'b1, 1'b1, 10000));
        script.push_back(item_row(32767, 32767, 32767, 32767, 32767, 1'b0, 1'b1, 32767));
        script.push_back(item_row(-32768, -32768, -32768, -32768, -32768, 1'b1, 1'b1, -32768));
        script.push_back(item_row(-1234, 5678, -9, 32000, -17, 1'b0));
        // Full-scale gains: both saturation bounds
        script.push_back(cfg_row(smx_pkg::REG_GAIN_ZERO, GAIN_MAX));
        script.push_back(cfg_row(smx_pkg::REG_GAIN_ONE, GAIN_MAX));
        script.push_back(cfg_row(smx_pkg::REG_GAIN_TWO, GAIN_MAX));
        script.push_back(cfg_row(smx_pkg::REG_GAIN_THREE, GAIN_MAX));
        script.push_back(item_row(-32768, 32767, 32767, 32767, 32767, 1'b0, 1'b1, 32767));
        script.push_back(item_row(32767, -32768, -32768, -32768, -32768, 1'b1, 1'b1, -32768));
        script.push_back(item_row(0, 1, 0, 0, 0, 1'b0));
        // Rounding either side of the half step, source zero alone at gain one
        script.push_back(cfg_row(smx_pkg::REG_ENABLE_MASK, 'h7FF1));
        script.push_back(cfg_row(smx_pkg::REG_GAIN_ZERO, 1));
        script.push_back(item_row(0, 8192, 32767, 32767, 32767, 1'b0, 1'b1, 1));
        script.push_back(item_row(0, 8191, 32767, 32767, 32767, 1'b1, 1'b1, 0));
        script.push_back(item_row(0, -8192, -32768, -32768, -32768, 1'b0, 1'b1, 0));
        script.push_back(item_row(0, -8193, -32768, -32768, -32768, 1'b1, 1'b1, -1));
        // Writes to undecoded indexes must change nothing
        script.push_back(cfg_row(IDX_SPARE_LO, 'h7FFF));
        script.push_back(cfg_row(IDX_SPARE_HI, 0));
        script.push_back(item_row(0, 8192, 0, 0, 0, 1'b0, 1'b1, 1));
        // Enabled source at zero gain contributes nothing
        script.push_back(cfg_row(smx_pkg::REG_ENABLE_MASK, 'h0012));
        script.push_back(cfg_row(smx_pkg::REG_GAIN_ONE, GAIN_NONE));
        script.push_back(item_row(777, 5, 32767, 9, 9, 1'b1, 1'b1, 777));
        script.push_back(cfg_row(smx_pkg::REG_GAIN_ONE, smx_pkg::GAIN_UNITY));
        script.push_back(item_row(100, 5, -300, 9, 9, 1'b0));
        // Uneven gains on all sources
        script.push_back(cfg_row(smx_pkg::REG_ENABLE_MASK, 'h000F));
        script.push_back(cfg_row(smx_pkg::REG_GAIN_ZERO, 20000));
        script.push_back(cfg_row(smx_pkg::REG_GAIN_TWO, 3));
        script.push_back(cfg_row(smx_pkg::REG_GAIN_THREE, 12345));
        script.push_back(item_row(-20000, 31000, -5, 29999, -32768, 1'b1));
        script.push_back(item_row(15000, -12345, 1, -29999, 32767, 1'b0));

        repeat (RESET_CYCLES) @(posedge clk);
        i_rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                drain_mixer();
                write_register(script[i].idx, script[i].data);
            end else begin
                push_frame(script[i].frame, script[i].fixed, script[i].want);
            end
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            setup_phase(ph);
            calm = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == PHASE_ITEMS / 2)
                    drain_mixer();
                push_frame(random_frame(), 1'b0, '0);
            end
            calm = 1'b0;
        end
        i_valid <= 1'b0;

        while (pending_mix.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        $display("Sent %0d sample frames across %0d register writes and %0d random phases",
                 frames_sent, reg_writes, PHASES);
        $display("Checked %0d mixed results, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: saturating_gain_audio_mixer.f
+incdir+design
design/smx_pkg.sv
design/smx_lane.sv
design/smx_mix.sv
design/saturating_gain_audio_mixer.sv
test/saturating_gain_audio_mixer_tb.sv
